/* sv/cref_pkg.sv */
// shared types, constants and accumulator helpers for the cell reference parser
package cref_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned IndexWidth = 32;
    localparam int unsigned TotalWidth = IndexWidth + 1;
    // widest value of total * 26 + 26 with total at most 2^32
    localparam int unsigned WideWidth  = TotalWidth + 5;
    localparam int unsigned StatusWidth = 3;
    localparam int unsigned OutDataWidth = 72;

    localparam logic [TotalWidth-1:0] LimitVal = {1'b1, {IndexWidth{1'b0}}};
    localparam logic [TotalWidth-1:0] SatVal   = {1'b1, {(IndexWidth-1){1'b0}}, 1'b1};

    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;
    localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
    localparam logic [CharWidth-1:0] CharUpZ   = 8'h5A;

    typedef enum logic [1:0] {
        PH_LETTER = 2'd0,
        PH_DIGIT  = 2'd1,
        PH_TAIL   = 2'd2
    } phase_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK         = 3'd0,
        ST_NO_DIGIT   = 3'd1,
        ST_NO_LETTERS = 3'd2,
        ST_BAD_LETTER = 3'd3,
        ST_ROW_BIG    = 3'd4,
        ST_COL_BIG    = 3'd5
    } status_t;

    // one accepted byte held in the input register
    typedef struct packed {
        logic                 valid;
        logic [CharWidth-1:0] char_code;
        logic                 last;
    } cref_item_t;

    // one finished reference on its way to the result register
    typedef struct packed {
        logic                  valid;
        logic [IndexWidth-1:0] column_index;
        logic [IndexWidth-1:0] row_index;
        status_t               status;
    } cref_result_t;

    // clamp a product-sum to the saturation marker once it passes 2^32
    function automatic logic [TotalWidth-1:0] sat_total(input logic [WideWidth-1:0] v);
        logic [TotalWidth-1:0] r;
        if (v > WideWidth'(LimitVal)) begin
            r = SatVal;
        end else begin
            r = v[TotalWidth-1:0];
        end
        return r;
    endfunction

    // total * 26 + add, saturating
    function automatic logic [TotalWidth-1:0] acc_base26(input logic [TotalWidth-1:0] total,
                                                         input logic [4:0] add);
        logic [WideWidth-1:0] t;
        logic [WideWidth-1:0] v;
        t = WideWidth'(total);
        v = (t << 4) + (t << 3) + (t << 1) + WideWidth'(add);
        return (total > LimitVal) ? SatVal : sat_total(v);
    endfunction

    // total * 10 + add, saturating
    function automatic logic [TotalWidth-1:0] acc_base10(input logic [TotalWidth-1:0] total,
                                                         input logic [3:0] add);
        logic [WideWidth-1:0] t;
        logic [WideWidth-1:0] v;
        t = WideWidth'(total);
        v = (t << 3) + (t << 1) + WideWidth'(add);
        return (total > LimitVal) ? SatVal : sat_total(v);
    endfunction

endpackage

/* sv/cell_reference_parser_top.sv */
// top level of the a1-style cell reference parser
// The block reads a spreadsheet cell reference such as AB12 one byte per transfer
// and, on the byte marked by tlast, returns one result transfer with the
// zero-based column, the row value minus one and a status code. Letters before
// the first digit are read as bijective base 26 (uppercase A to Z only), the
// first digit run gives the row, and anything after that run is ignored. A
// non-ok status forces both indexes to zero. Throughput is one byte per clock
// cycle unless a last byte is held back, limited by the multiply-add state update
// (times 26 for letters, times 10 for digits); a result passes from the parse
// logic into the result register on the master side. Bytes that do not end a
// reference keep flowing while a result waits; only a last byte stalls while
// the result register is still full. State clears after each finished reference.
module cell_reference_parser_top
    import cref_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // input byte stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [CharWidth-1:0]    s_tdata,   // [7:0] char_code
    input  logic                    s_tlast,   // final byte of the reference
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataWidth-1:0] m_tdata    // [31:0] column_index, [63:32] row_index,
                                               // [66:64] status, [71:67] zero
);

    cref_item_t   item;
    cref_result_t result;
    logic         advance;
    logic         out_free;

    // input register, refilled in the same cycle it drains
    cref_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .item     (item)
    );

    // parse state and status evaluation
    cref_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .out_free (out_free),
        .advance  (advance),
        .result   (result)
    );

    // result register
    cref_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/cref_in_stage.sv */
// input register: holds one accepted byte until the parse stage consumes it
module cref_in_stage
    import cref_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CharWidth-1:0] s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,
    input  logic                 advance,
    output cref_item_t           item
);

    logic                 valid_reg, valid_next;
    logic [CharWidth-1:0] char_reg;
    logic                 last_reg;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item.valid     = valid_reg;
    assign item.char_code = char_reg;
    assign item.last      = last_reg;

endmodule

/* sv/cref_parse.sv */
// per-byte state update and end-of-reference status evaluation
module cref_parse
    import cref_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cref_item_t   item,
    input  logic         out_free,
    output logic         advance,
    output cref_result_t result
);

    phase_t                phase_reg, phase_next;
    logic [TotalWidth-1:0] col_reg, col_next;
    logic [TotalWidth-1:0] row_reg, row_next;
    logic                  seen_reg, seen_next;
    logic                  fault_reg, fault_next;

    logic                  is_digit;
    logic                  is_upper;
    logic [3:0]            digit_val;
    logic [4:0]            letter_val;
    logic [TotalWidth-1:0] col_m1;
    logic [TotalWidth-1:0] row_m1;
    status_t               status;

    // a byte leaves the input register unless its result would find the output full
    assign advance = item.valid && (!item.last || out_free);

    assign is_digit   = (item.char_code >= CharZero) && (item.char_code <= CharNine);
    assign is_upper   = (item.char_code >= CharUpA) && (item.char_code <= CharUpZ);
    assign digit_val  = 4'(item.char_code - CharZero);
    assign letter_val = 5'(item.char_code - CharUpA + 8'd1);

    // state after this byte
    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        seen_next  = seen_reg;
        fault_next = fault_reg;
        unique case (phase_reg)
            PH_LETTER: begin
                if (is_digit) begin
                    phase_next = PH_DIGIT;
                    row_next   = TotalWidth'(digit_val);
                end else begin
                    seen_next = 1'b1;
                    if (!is_upper) begin
                        fault_next = 1'b1;
                    end else if (!fault_reg) begin
                        col_next = acc_base26(col_reg, letter_val);
                    end
                end
            end
            PH_DIGIT: begin
                if (is_digit) begin
                    row_next = acc_base10(row_reg, digit_val);
                end else begin
                    phase_next = PH_TAIL;
                end
            end
            default: begin
                // trailing text is ignored
            end
        endcase
    end

    // status precedence: no digit, no letters, bad letter, column, row
    always_comb begin
        if (phase_next == PH_LETTER) begin
            status = ST_NO_DIGIT;
        end else if (!seen_next) begin
            status = ST_NO_LETTERS;
        end else if (fault_next) begin
            status = ST_BAD_LETTER;
        end else if (col_next > LimitVal) begin
            status = ST_COL_BIG;
        end else if (row_next > LimitVal) begin
            status = ST_ROW_BIG;
        end else begin
            status = ST_OK;
        end
    end

    assign col_m1 = col_next - TotalWidth'(1);
    assign row_m1 = row_next - TotalWidth'(1);

    assign result.valid        = advance && item.last;
    assign result.status       = status;
    assign result.column_index = (status == ST_OK) ? col_m1[IndexWidth-1:0] : '0;
    assign result.row_index    = (status == ST_OK) ? row_m1[IndexWidth-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LETTER;
            col_reg   <= '0;
            row_reg   <= '0;
            seen_reg  <= 1'b0;
            fault_reg <= 1'b0;
        end else if (advance) begin
            if (item.last) begin
                // a finished reference leaves a clean slate for the next one
                phase_reg <= PH_LETTER;
                col_reg   <= '0;
                row_reg   <= '0;
                seen_reg  <= 1'b0;
                fault_reg <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                seen_reg  <= seen_next;
                fault_reg <= fault_next;
            end
        end
    end

endmodule

/* sv/cref_out_stage.sv */
// result register on the master side
module cref_out_stage
    import cref_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cref_result_t            result,
    output logic                    out_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataWidth-1:0] m_tdata
);

    logic                  valid_reg, valid_next;
    logic [IndexWidth-1:0] col_reg;
    logic [IndexWidth-1:0] row_reg;
    status_t               status_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (result.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            col_reg    <= result.column_index;
            row_reg    <= result.row_index;
            status_reg <= result.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OutDataWidth - 2*IndexWidth - StatusWidth){1'b0}},
                       status_reg, row_reg, col_reg};

endmodule

/* test/tb_cref_pkg.sv */
// scoreboard class that predicts and checks the parsed cell references
`timescale 1ns / 100ps

package tb_cref_pkg;
    import cref_pkg::*;

    typedef struct {
        logic [IndexWidth-1:0] column;
        logic [IndexWidth-1:0] row;
        status_t               status;
    } cell_t;

    class cell_ref_checker;
        cell_t                 expected_cells[$];
        phase_t                phase;
        logic [TotalWidth-1:0] column_total;
        logic [TotalWidth-1:0] row_total;
        bit                    letter_seen;
        status_t               fault;
        int unsigned           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase        = PH_LETTER;
            column_total = '0;
            row_total    = '0;
            letter_seen  = 1'b0;
            fault        = ST_OK;
        endfunction

        // total * radix + digit, pinned at the saturation marker past 2^32
        function logic [TotalWidth-1:0] grow(input logic [TotalWidth-1:0] total,
                                             input int unsigned radix,
                                             input int unsigned digit);
            longint unsigned v;
            if (total > LimitVal) return SatVal;
            v = longint'(total) * longint'(radix) + longint'(digit);
            if (v > longint'(LimitVal)) return SatVal;
            return v[TotalWidth-1:0];
        endfunction

        function int unsigned pending();
            return expected_cells.size();
        endfunction

        // one accepted byte; a byte marked last queues the expected reference
        function void take_char(input logic [CharWidth-1:0] code, input logic is_last);
            bit    is_digit;
            cell_t entry;
            is_digit = (code >= CharZero) && (code <= CharNine);
            case (phase)
                PH_LETTER: begin
                    if (is_digit) begin
                        phase     = PH_DIGIT;
                        row_total = TotalWidth'(code - CharZero);
                    end else begin
                        letter_seen = 1'b1;
                        if (code < CharUpA || code > CharUpZ) begin
                            fault = ST_BAD_LETTER;
                        end else if (fault == ST_OK) begin
                            column_total = grow(column_total, 26, 32'(code - CharUpA + 8'd1));
                        end
                    end
                end
                PH_DIGIT: begin
                    if (is_digit) begin
                        row_total = grow(row_total, 10, 32'(code - CharZero));
                    end else begin
                        phase = PH_TAIL;
                    end
                end
                default: ;
            endcase
            if (!is_last) return;
            entry.column = '0;
            entry.row    = '0;
            if (phase == PH_LETTER) begin
                entry.status = ST_NO_DIGIT;
            end else if (!letter_seen) begin
                entry.status = ST_NO_LETTERS;
            end else if (fault != ST_OK) begin
                entry.status = fault;
            end else if (column_total > LimitVal) begin
                entry.status = ST_COL_BIG;
            end else if (row_total > LimitVal) begin
                entry.status = ST_ROW_BIG;
            end else begin
                entry.status = ST_OK;
                // row text 0 wraps to all ones here
                entry.column = IndexWidth'(column_total - 1'b1);
                entry.row    = IndexWidth'(row_total - 1'b1);
            end
            expected_cells.push_back(entry);
            clear();
        endfunction

        function void check_cell(input logic [OutDataWidth-1:0] data);
            cell_t                 want;
            logic [IndexWidth-1:0] got_column;
            logic [IndexWidth-1:0] got_row;
            logic [StatusWidth-1:0] got_status;
            logic [4:0]            got_pad;
            got_column = data[31:0];
            got_row    = data[63:32];
            got_status = data[66:64];
            got_pad    = data[71:67];
            if (expected_cells.size() == 0) begin
                $error("unexpected result: column_index %0h row_index %0h status %0d",
                       got_column, got_row, got_status);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (got_column !== want.column) begin
                $error("column_index: expected %0h, got %0h", want.column, got_column);
                errors++;
            end
            if (got_row !== want.row) begin
                $error("row_index: expected %0h, got %0h", want.row, got_row);
                errors++;
            end
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_pad !== 5'd0) begin
                $error("pad: expected 0, got %0h", got_pad);
                errors++;
            end
        endfunction
    endclass

endpackage

/* test/tb_top.sv */
// testbench top for the cell reference parser: byte stream in, parsed references out
`timescale 1ns / 100ps

module tb_top;
    import cref_pkg::*;
    import tb_cref_pkg::*;

    localparam int unsigned CharTarget = 1000;    // stop the random part after this many bytes
    localparam int unsigned CycleLimit = 200000;  // far above the slowest legal run
    localparam int unsigned HoldCycles = 400;     // long receiver hold-off
    localparam int unsigned DrainCycles = 16;     // wait after the drain for stray extra results

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [CharWidth-1:0]    s_tdata  = '0;
    logic                    s_tlast  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;

    cell_ref_checker cells = new();

    int unsigned chars_sent  = 0;
    int unsigned burst_left  = 1;
    int unsigned cells_seen  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_cycle    = 0;
    int unsigned rx_mode     = 0;
    bit          hold_off    = 1'b0;

    always #10 aclk = ~aclk;

    cell_reference_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // offer one byte and hold it until the transfer happens
    // the sender runs in bursts; a gap only opens once a burst is used up
    task automatic send_byte(input logic [CharWidth-1:0] code, input logic is_last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        cells.take_char(code, is_last);
        chars_sent++;
        burst_left--;
        if (burst_left == 0) begin
            // mostly short bursts, now and then a long run with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // send a string; its final byte carries tlast only when ends is set
    task automatic send_text(input string text, input bit ends);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], ends && (i == text.len() - 1));
        end
    endtask

    function automatic logic [CharWidth-1:0] non_digit();
        logic [CharWidth-1:0] b;
        do b = CharWidth'($urandom_range(0, 255)); while (b >= CharZero && b <= CharNine);
        return b;
    endfunction

    // letters, a digit run and maybe trailing text, or now and then any bytes at all;
    // sizes lean small but sometimes run long enough to saturate the column or the row
    task automatic send_random_reference();
        logic [CharWidth-1:0] text[$];
        int unsigned          n_letters;
        int unsigned          n_digits;
        int unsigned          n_tail;
        int unsigned          pick;
        bit                   wide_column;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // garbage reference, any bytes at all
            repeat ($urandom_range(1, 6)) text.push_back(CharWidth'($urandom_range(0, 255)));
        end else begin
            wide_column = (pick == 1);
            n_letters   = (pick == 2) ? 0 : wide_column ? $urandom_range(6, 8)
                                                        : $urandom_range(1, 3);
            pick        = $urandom_range(0, 19);
            n_digits    = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(10, 12)
                                                        : $urandom_range(1, 6);
            n_tail      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (int i = 0; i < n_letters; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    text.push_back(non_digit());
                end else if (wide_column) begin
                    text.push_back(CharWidth'($urandom_range(CharUpA + 12, CharUpZ)));
                end else begin
                    text.push_back(CharWidth'($urandom_range(CharUpA, CharUpZ)));
                end
            end
            for (int i = 0; i < n_digits; i++) begin
                text.push_back(CharWidth'($urandom_range(CharZero, CharNine)));
            end
            // the first trailing byte must end the digit run
            for (int i = 0; i < n_tail; i++) begin
                text.push_back((i == 0) ? non_digit() : CharWidth'($urandom_range(0, 255)));
            end
            if (text.size() == 0) text.push_back(CharWidth'($urandom_range(0, 255)));
        end
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    // receiver: counts results and stalls on a pattern picked at random from three modes
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            cells.check_cell(m_tdata);
            cells_seen <= cells_seen + 1;
        end
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
        if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;                       // no stalls
                1:       m_tready <= 1'($urandom_range(0, 1));   // coin flip
                default: m_tready <= (rx_cycle % 5 != 3);        // one stall in five
            endcase
        end
    end

    // long hold-off once traffic is flowing, so a last byte backs up the input
    initial begin
        do @(posedge aclk); while (cells_seen < 30);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed references
        send_text("A0", 1);                 // row zero wraps to all ones
        send_text("7", 1);                  // lone digit, no letters
        send_text("Z", 1);                  // lone letter, no digit
        send_text("a1", 1);                 // lowercase is illegal
        send_byte(8'hFF, 1'b0);             // top byte as an illegal letter
        send_text("2", 1);
        send_text("C3", 0);                 // trailing text with a nul and a digit
        send_byte(8'h00, 1'b0);
        send_text("9", 1);
        send_text("ZZZZZZZ1", 1);           // column past 2^32
        send_text("A4294967297", 1);        // row past 2^32

        while (chars_sent < CharTarget) send_random_reference();
        s_tvalid <= 1'b0;

        // drain every outstanding result, then allow for stray extras
        while (cells.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (cells.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/cref_pkg.sv
sv/cref_in_stage.sv
sv/cref_parse.sv
sv/cref_out_stage.sv
sv/cell_reference_parser_top.sv
test/tb_cref_pkg.sv
test/tb_top.sv
